>>> rtl/wtms_pkg.sv
// Package: shared constants, types and helpers for the trimmed mean / stddev block.
`timescale 1ns / 1ps
package wtms_pkg;

  localparam int MAX_SIDE    = 32;
  localparam int MAX_SAMPLES = 1024;
  localparam int SIDE_W      = 6;
  localparam int PIX_W       = 16;
  localparam int FRAC_W      = 17;
  localparam int CNT_W       = $clog2(MAX_SAMPLES) + 1;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int PC_W        = $clog2(MAX_SIDE * MAX_SIDE) + 1;
  localparam int S1_W        = PIX_W + ADDR_W;
  localparam int S2_W        = 2 * PIX_W + ADDR_W;
  localparam int PROD_W      = S2_W + CNT_W;
  localparam int SQ_W        = 2 * S1_W;
  localparam int DVD_W       = PROD_W + 16;
  localparam int DEN_W       = 2 * ADDR_W;
  localparam int ITER_W      = $clog2(DVD_W + 1);
  localparam int SQRT_W      = 50;
  localparam int OUT_W       = 24;
  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_EMPTY  = 2'd1;
  localparam logic [1:0] STAT_SINGLE = 2'd2;

  localparam logic REG_LOW  = 1'b0;
  localparam logic REG_HIGH = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PDIV, ST_KEEP, ST_INS_RD, ST_INS_CMP, ST_INS_PUT, ST_POST,
    ST_TRIM_L, ST_TRIM_H, ST_RANGE, ST_ACC_RD, ST_ACC_MUL, ST_ACC_ADD,
    ST_MEAN, ST_MUL_LO, ST_MUL_HI, ST_SQ, ST_SUB, ST_VSTART, ST_VDIV,
    ST_SQRT, ST_DONE
  } state_e;

  typedef struct packed {
    logic                start;
    logic [DVD_W-1:0]    dividend;  // left aligned
    logic [DEN_W-1:0]    divisor;
    logic [ITER_W-1:0]   iters;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic                busy;
    logic [DVD_W-1:0]    quotient;
    logic [DEN_W-1:0]    remainder;
  } div_rsp_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) r = SIDE_W'(1);
    else if (v > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
    return r;
  endfunction

endpackage

>>> rtl/wtms_if.sv
// Stream interfaces for pixel input and result output.
`timescale 1ns / 1ps
interface wtms_in_if;
  logic                           valid;
  logic                           ready;
  logic [wtms_pkg::PIX_W-1:0]     pixel_value;
  logic [wtms_pkg::SIDE_W-1:0]    window_width;
  logic [wtms_pkg::SIDE_W-1:0]    window_height;
  logic                           last_pixel;
  modport source(output valid, pixel_value, window_width, window_height, last_pixel,
                 input ready);
  modport sink(input valid, pixel_value, window_width, window_height, last_pixel,
               output ready);
endinterface

interface wtms_out_if;
  logic                           valid;
  logic                           ready;
  logic [wtms_pkg::OUT_W-1:0]     trimmed_mean;
  logic [wtms_pkg::OUT_W-1:0]     trimmed_stddev;
  logic [wtms_pkg::CNT_W-1:0]     kept_count;
  logic [1:0]                     status;
  modport source(output valid, trimmed_mean, trimmed_stddev, kept_count, status,
                 input ready);
  modport sink(input valid, trimmed_mean, trimmed_stddev, kept_count, status,
               output ready);
endinterface

>>> rtl/wtms_div.sv
// Bit-serial restoring divider shared by position, mean and variance steps.
`timescale 1ns / 1ps
module wtms_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wtms_pkg::div_req_t req_i,
  output wtms_pkg::div_rsp_t rsp_o
);
  logic [wtms_pkg::DVD_W-1:0]  dvd_q, dvd_d, quo_q, quo_d;
  logic [wtms_pkg::DEN_W-1:0]  den_q, den_d, rem_q, rem_d;
  logic [wtms_pkg::ITER_W-1:0] cnt_q, cnt_d;
  logic                        busy_q, busy_d, done_q, done_d;
  logic [wtms_pkg::DEN_W:0]    sh;

  always_comb begin
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    sh     = {rem_q, dvd_q[wtms_pkg::DVD_W-1]};
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      den_d  = req_i.divisor;
      cnt_d  = req_i.iters;
      rem_d  = '0;
      quo_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      if (sh >= {1'b0, den_q}) begin
        rem_d = wtms_pkg::DEN_W'(sh - {1'b0, den_q});
        quo_d = {quo_q[wtms_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_d = sh[wtms_pkg::DEN_W-1:0];
        quo_d = {quo_q[wtms_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == wtms_pkg::ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.busy      = busy_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;
endmodule

>>> rtl/window_trimmed_mean_stddev_top.sv
// Top level: window trimmed mean and sample standard deviation.
`timescale 1ns / 1ps
// Takes one pixel per transaction and returns one result after the pixel flagged
// last. A dropped pixel passes the accept step, the serial divider for its
// row/column split, the keep test and the counter update. A kept pixel is also
// stored, and each larger sample already stored is moved up one place while it
// is sorted in (one write port and one registered read port on the sample
// memory, one read and one write per step). After the last pixel come the trim
// bounds, the sums over the kept samples, the mean division, the products, the
// variance division, the square root and the hand-over of the result.
// The sample memory needs no clearing after reset. A result waits in an output
// register, so the next window may start while it is pending.
module window_trimmed_mean_stddev_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [wtms_pkg::FRAC_W-1:0]        cfg_data_i,
  wtms_in_if.sink                            in_if,
  wtms_out_if.source                         out_if
);
  localparam int AW = wtms_pkg::ADDR_W;
  localparam int CW = wtms_pkg::CNT_W;
  localparam int LW = CW + 32;
  localparam int HW = CW + wtms_pkg::S2_W - 32;

  wtms_pkg::state_e state_q, state_d;
  wtms_pkg::div_req_t div_req;
  wtms_pkg::div_rsp_t div_rsp;

  logic [wtms_pkg::FRAC_W-1:0] low_q, high_q, cfg_sat;
  logic [wtms_pkg::PC_W-1:0]   pc_q, pc_d;
  logic [CW-1:0]               kc_q, kc_d, j_q, j_d, l_q, l_d, h_q, h_d, i_q, i_d;
  logic [CW-1:0]               cnt_q, cnt_d, row_q, row_d;
  logic [wtms_pkg::PIX_W-1:0]  pix_q, pix_d, rdata_q;
  logic [wtms_pkg::SIDE_W-1:0] w_q, w_d, ht_q, ht_d, col_q, col_d, w_in;
  logic                        last_q, last_d;
  logic [wtms_pkg::S1_W-1:0]   s1_q, s1_d;
  logic [wtms_pkg::S2_W-1:0]   s2_q, s2_d;
  logic [2*wtms_pkg::PIX_W-1:0] xsq_q, xsq_d;
  logic [wtms_pkg::PROD_W-1:0] prod_q, prod_d, num_q, num_d;
  logic [wtms_pkg::SQ_W-1:0]   sq_q, sq_d;
  logic [wtms_pkg::DEN_W-1:0]  den_q, den_d;
  logic [wtms_pkg::SQRT_W-1:0] sv_q, sv_d, sres_q, sres_d, sbit_q, sbit_d, ssum;
  logic [wtms_pkg::OUT_W-1:0]  mean_q, mean_d, sd_q, sd_d;
  logic [1:0]                  stat_q, stat_d;
  logic [wtms_pkg::OUT_W-1:0]  om_q, om_d, os_q, os_d;
  logic [CW-1:0]               oc_q, oc_d;
  logic [1:0]                  ost_q, ost_d;
  logic                        ov_q, ov_d;
  logic [wtms_pkg::FRAC_W+CW-1:0] trim_prod;
  logic [wtms_pkg::FRAC_W+CW-17:0] trim_raw;
  logic                        keep_c, keep_r;

  logic [wtms_pkg::PIX_W-1:0]  mem [wtms_pkg::MAX_SAMPLES];
  logic                        mem_we;
  logic [AW-1:0]               mem_wa, mem_ra;
  logic [wtms_pkg::PIX_W-1:0]  mem_wd;

  wtms_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));

  assign cfg_sat = (cfg_data_i > wtms_pkg::FRAC_ONE) ? wtms_pkg::FRAC_ONE : cfg_data_i;
  assign w_in    = wtms_pkg::clamp_side(in_if.window_width);
  assign in_if.ready = (state_q == wtms_pkg::ST_IDLE);

  always_comb begin
    keep_c = (w_q > wtms_pkg::SIDE_W'(3)) ?
             (col_q >= wtms_pkg::SIDE_W'(1) && col_q < w_q - 1'b1) : 1'b1;
    keep_r = (ht_q > wtms_pkg::SIDE_W'(3)) ?
             (row_q >= CW'(1) && row_q < CW'(ht_q - 1'b1)) : (row_q < CW'(ht_q));
  end

  always_comb begin
    state_d = state_q;
    pc_d = pc_q; kc_d = kc_q; j_d = j_q; l_d = l_q; h_d = h_q; i_d = i_q;
    cnt_d = cnt_q; row_d = row_q; col_d = col_q;
    pix_d = pix_q; w_d = w_q; ht_d = ht_q; last_d = last_q;
    s1_d = s1_q; s2_d = s2_q; xsq_d = xsq_q; prod_d = prod_q; num_d = num_q;
    sq_d = sq_q; den_d = den_q; sv_d = sv_q; sres_d = sres_q; sbit_d = sbit_q;
    mean_d = mean_q; sd_d = sd_q; stat_d = stat_q;
    om_d = om_q; os_d = os_q; oc_d = oc_q; ost_d = ost_q;
    ov_d = ov_q & ~out_if.ready;
    div_req = '0;
    mem_we = 1'b0; mem_wa = j_q[AW-1:0]; mem_wd = pix_q;
    mem_ra = AW'(j_q - 1'b1);
    trim_prod = '0;
    trim_raw  = '0;
    ssum = sres_q + sbit_q;

    unique case (state_q)
      wtms_pkg::ST_IDLE: begin
        if (in_if.valid) begin
          pix_d  = in_if.pixel_value;
          w_d    = w_in;
          ht_d   = wtms_pkg::clamp_side(in_if.window_height);
          last_d = in_if.last_pixel;
          div_req.start    = 1'b1;
          div_req.dividend = {pc_q, (wtms_pkg::DVD_W - wtms_pkg::PC_W)'(0)};
          div_req.divisor  = wtms_pkg::DEN_W'(w_in);
          div_req.iters    = wtms_pkg::ITER_W'(wtms_pkg::PC_W);
          state_d = wtms_pkg::ST_PDIV;
        end
      end
      wtms_pkg::ST_PDIV: begin
        if (div_rsp.done) begin
          row_d = div_rsp.quotient[CW-1:0];
          col_d = div_rsp.remainder[wtms_pkg::SIDE_W-1:0];
          state_d = wtms_pkg::ST_KEEP;
        end
      end
      wtms_pkg::ST_KEEP: begin
        state_d = wtms_pkg::ST_POST;
        if (keep_c && keep_r && kc_q < CW'(wtms_pkg::MAX_SAMPLES)) begin
          kc_d = kc_q + 1'b1;
          j_d  = kc_q;
          state_d = (kc_q == '0) ? wtms_pkg::ST_INS_PUT : wtms_pkg::ST_INS_RD;
        end
      end
      wtms_pkg::ST_INS_RD: state_d = wtms_pkg::ST_INS_CMP;
      wtms_pkg::ST_INS_CMP: begin
        mem_we = 1'b1;
        if (rdata_q > pix_q) begin
          mem_wd = rdata_q;
          j_d = j_q - 1'b1;
          state_d = (j_q == CW'(1)) ? wtms_pkg::ST_INS_PUT : wtms_pkg::ST_INS_RD;
        end else begin
          state_d = wtms_pkg::ST_POST;
        end
      end
      wtms_pkg::ST_INS_PUT: begin
        mem_we = 1'b1;
        state_d = wtms_pkg::ST_POST;
      end
      wtms_pkg::ST_POST: begin
        if (pc_q < wtms_pkg::PC_W'(wtms_pkg::MAX_SIDE * wtms_pkg::MAX_SIDE)) pc_d = pc_q + 1'b1;
        state_d = last_q ? wtms_pkg::ST_TRIM_L : wtms_pkg::ST_IDLE;
      end
      wtms_pkg::ST_TRIM_L: begin
        trim_prod = low_q * kc_q;
        trim_raw  = trim_prod[wtms_pkg::FRAC_W+CW-1:16];
        l_d = (trim_raw > (wtms_pkg::FRAC_W+CW-16)'(kc_q)) ? kc_q : CW'(trim_raw);
        state_d = wtms_pkg::ST_TRIM_H;
      end
      wtms_pkg::ST_TRIM_H: begin
        trim_prod = high_q * kc_q;
        trim_raw  = trim_prod[wtms_pkg::FRAC_W+CW-1:16];
        h_d = (trim_raw > (wtms_pkg::FRAC_W+CW-16)'(kc_q)) ? kc_q : CW'(trim_raw);
        state_d = wtms_pkg::ST_RANGE;
      end
      wtms_pkg::ST_RANGE: begin
        s1_d = '0; s2_d = '0; i_d = l_q;
        cnt_d = h_q - l_q;
        if (h_q <= l_q) begin
          cnt_d = '0; mean_d = '0; sd_d = '0;
          stat_d = wtms_pkg::STAT_EMPTY;
          state_d = wtms_pkg::ST_DONE;
        end else begin
          state_d = wtms_pkg::ST_ACC_RD;
        end
      end
      wtms_pkg::ST_ACC_RD: begin
        mem_ra = i_q[AW-1:0];
        state_d = wtms_pkg::ST_ACC_MUL;
      end
      wtms_pkg::ST_ACC_MUL: begin
        xsq_d = rdata_q * rdata_q;
        s1_d  = s1_q + wtms_pkg::S1_W'(rdata_q);
        state_d = wtms_pkg::ST_ACC_ADD;
      end
      wtms_pkg::ST_ACC_ADD: begin
        s2_d = s2_q + wtms_pkg::S2_W'(xsq_q);
        i_d  = i_q + 1'b1;
        if (i_q + 1'b1 == h_q) begin
          div_req.start    = 1'b1;
          div_req.dividend = {s1_q, 8'd0, (wtms_pkg::DVD_W - wtms_pkg::S1_W - 8)'(0)};
          div_req.divisor  = wtms_pkg::DEN_W'(cnt_q);
          div_req.iters    = wtms_pkg::ITER_W'(wtms_pkg::S1_W + 8);
          state_d = wtms_pkg::ST_MEAN;
        end else begin
          state_d = wtms_pkg::ST_ACC_RD;
        end
      end
      wtms_pkg::ST_MEAN: begin
        if (div_rsp.done) begin
          mean_d = (div_rsp.quotient > wtms_pkg::DVD_W'({wtms_pkg::OUT_W{1'b1}})) ?
                   {wtms_pkg::OUT_W{1'b1}} : div_rsp.quotient[wtms_pkg::OUT_W-1:0];
          if (cnt_q == CW'(1)) begin
            sd_d = '0;
            stat_d = wtms_pkg::STAT_SINGLE;
            state_d = wtms_pkg::ST_DONE;
          end else begin
            state_d = wtms_pkg::ST_MUL_LO;
          end
        end
      end
      wtms_pkg::ST_MUL_LO: begin
        prod_d = wtms_pkg::PROD_W'(LW'(cnt_q) * LW'(s2_q[31:0]));
        den_d  = wtms_pkg::DEN_W'(cnt_q) * wtms_pkg::DEN_W'(cnt_q - 1'b1);
        state_d = wtms_pkg::ST_MUL_HI;
      end
      wtms_pkg::ST_MUL_HI: begin
        prod_d = prod_q + wtms_pkg::PROD_W'(
                 {HW'(cnt_q) * HW'(s2_q[wtms_pkg::S2_W-1:32]), 32'd0});
        state_d = wtms_pkg::ST_SQ;
      end
      wtms_pkg::ST_SQ: begin
        sq_d = s1_q * s1_q;
        state_d = wtms_pkg::ST_SUB;
      end
      wtms_pkg::ST_SUB: begin
        num_d = prod_q - wtms_pkg::PROD_W'(sq_q);
        state_d = wtms_pkg::ST_VSTART;
      end
      wtms_pkg::ST_VSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = {num_q, 16'd0};
        div_req.divisor  = den_q;
        div_req.iters    = wtms_pkg::ITER_W'(wtms_pkg::DVD_W);
        state_d = wtms_pkg::ST_VDIV;
      end
      wtms_pkg::ST_VDIV: begin
        if (div_rsp.done) begin
          sv_d   = div_rsp.quotient[wtms_pkg::SQRT_W-1:0];
          sres_d = '0;
          sbit_d = wtms_pkg::SQRT_W'(1) << 48;
          state_d = wtms_pkg::ST_SQRT;
        end
      end
      wtms_pkg::ST_SQRT: begin
        if (sv_q >= ssum) begin
          sv_d   = sv_q - ssum;
          sres_d = (sres_q >> 1) + sbit_q;
        end else begin
          sres_d = sres_q >> 1;
        end
        sbit_d = sbit_q >> 2;
        if (sbit_q[0]) begin
          sd_d = (sres_d > wtms_pkg::SQRT_W'({wtms_pkg::OUT_W{1'b1}})) ?
                 {wtms_pkg::OUT_W{1'b1}} : sres_d[wtms_pkg::OUT_W-1:0];
          stat_d = wtms_pkg::STAT_OK;
          state_d = wtms_pkg::ST_DONE;
        end
      end
      wtms_pkg::ST_DONE: begin
        if (!ov_q || out_if.ready) begin
          ov_d = 1'b1;
          om_d = mean_q; os_d = sd_q; oc_d = cnt_q; ost_d = stat_q;
          pc_d = '0; kc_d = '0;
          state_d = wtms_pkg::ST_IDLE;
        end
      end
      default: state_d = wtms_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wtms_pkg::ST_IDLE;
      pc_q    <= '0;
      kc_q    <= '0;
      ov_q    <= 1'b0;
      low_q   <= '0;
      high_q  <= wtms_pkg::FRAC_ONE;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      kc_q    <= kc_d;
      ov_q    <= ov_d;
      if (cfg_we_i && cfg_idx_i == wtms_pkg::REG_LOW)  low_q  <= cfg_sat;
      if (cfg_we_i && cfg_idx_i == wtms_pkg::REG_HIGH) high_q <= cfg_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q <= j_d; l_q <= l_d; h_q <= h_d; i_q <= i_d; cnt_q <= cnt_d;
    row_q <= row_d; col_q <= col_d; pix_q <= pix_d; w_q <= w_d; ht_q <= ht_d;
    last_q <= last_d; s1_q <= s1_d; s2_q <= s2_d; xsq_q <= xsq_d;
    prod_q <= prod_d; num_q <= num_d; sq_q <= sq_d; den_q <= den_d;
    sv_q <= sv_d; sres_q <= sres_d; sbit_q <= sbit_d;
    mean_q <= mean_d; sd_q <= sd_d; stat_q <= stat_d;
    om_q <= om_d; os_q <= os_d; oc_q <= oc_d; ost_q <= ost_d;
  end

  // sample memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[mem_ra];
  end

  assign out_if.valid          = ov_q;
  assign out_if.trimmed_mean   = om_q;
  assign out_if.trimmed_stddev = os_q;
  assign out_if.kept_count     = oc_q;
  assign out_if.status         = ost_q;

  a_kc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kc_q <= CW'(wtms_pkg::MAX_SAMPLES))
    else $error("kept count above store depth");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wtms_pkg::ST_IDLE |-> !div_rsp.busy)
    else $error("divider busy while idle");

  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wtms_pkg::ST_DONE && (!ov_q || out_if.ready)) |=>
      (ov_q && pc_q == '0 && kc_q == '0))
    else $error("result not loaded or counters not cleared");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wtms_pkg::ST_ACC_RD |-> (i_q < h_q && h_q <= kc_q))
    else $error("accumulation index out of range");
endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the window trimmed mean / stddev block.
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic [wtms_pkg::PIX_W-1:0]  pix;
    logic [wtms_pkg::SIDE_W-1:0] w;
    logic [wtms_pkg::SIDE_W-1:0] h;
    logic                        last;
  } pixel_t;

  typedef struct packed {
    logic [wtms_pkg::OUT_W-1:0] mean;
    logic [wtms_pkg::OUT_W-1:0] sd;
    logic [wtms_pkg::CNT_W-1:0] cnt;
    logic [1:0]                 stat;
  } stats_t;

  logic clk_i, rst_ni, cfg_we_i, cfg_idx_i;
  logic [wtms_pkg::FRAC_W-1:0] cfg_data_i;

  wtms_in_if  in_if();
  wtms_out_if out_if();

  window_trimmed_mean_stddev_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(in_if.sink), .out_if(out_if.source)
  );

  pixel_t pixel_q[$];
  stats_t expected_stats_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  bit long_hold_req = 0;
  bit in_taken = 0;

  // predictor state
  logic [16:0] low_frac = 17'd0, high_frac = 17'd65536;
  logic [15:0] samples[$];
  int unsigned pix_pos = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic int unsigned side_of(logic [wtms_pkg::SIDE_W-1:0] v);
    if (v == 0) return 1;
    if (v > wtms_pkg::MAX_SIDE) return wtms_pkg::MAX_SIDE;
    return 32'(v);
  endfunction

  task automatic predict_window_stats(pixel_t p);
    int unsigned w, ht, col, row, n, lo, hi, cnt;
    longint unsigned s1, s2, num, d, var_q, mean, sd;
    logic [15:0] sorted[$];
    stats_t r;
    w = side_of(p.w);
    ht = side_of(p.h);
    col = pix_pos % w;
    row = pix_pos / w;
    if (col >= (w > 3 ? 1 : 0) && col < (w > 3 ? w - 1 : w) &&
        row >= (ht > 3 ? 1 : 0) && row < (ht > 3 ? ht - 1 : ht) &&
        samples.size() < wtms_pkg::MAX_SAMPLES)
      samples.insert(samples.size(), p.pix);
    if (pix_pos < wtms_pkg::MAX_SIDE * wtms_pkg::MAX_SIDE) pix_pos++;
    if (!p.last) return;
    sorted = samples;
    sorted.sort();
    n = sorted.size();
    lo = (longint'(low_frac) * n) >> 16;
    hi = (longint'(high_frac) * n) >> 16;
    if (hi > n) hi = n;
    if (lo > n) lo = n;
    s1 = 0; s2 = 0; mean = 0; sd = 0;
    if (hi <= lo) begin
      cnt = 0;
      r.stat = wtms_pkg::STAT_EMPTY;
    end else begin
      cnt = hi - lo;
      for (int i = lo; i < hi; i++) begin
        s1 += sorted[i];
        s2 += longint'(sorted[i]) * sorted[i];
      end
      mean = (s1 << 8) / cnt;
      if (cnt == 1) begin
        r.stat = wtms_pkg::STAT_SINGLE;
      end else begin
        num = cnt * s2 - s1 * s1;
        d = longint'(cnt) * (cnt - 1);
        var_q = (num / d) * 65536 + ((num % d) * 65536) / d;
        sd = int_sqrt(var_q);
        if (sd > 24'hFFFFFF) sd = 24'hFFFFFF;
        r.stat = wtms_pkg::STAT_OK;
      end
    end
    if (mean > 24'hFFFFFF) mean = 24'hFFFFFF;
    r.mean = wtms_pkg::OUT_W'(mean);
    r.sd = wtms_pkg::OUT_W'(sd);
    r.cnt = wtms_pkg::CNT_W'(cnt);
    expected_stats_q.insert(expected_stats_q.size(), r);
    samples.delete();
    pix_pos = 0;
  endtask

  task automatic report_mismatch(string what, longint got, longint exp_v);
    $display("MISMATCH %s: got %0d expected %0d", what, got, exp_v);
    errors++;
  endtask

  // driver: bursts and gaps; a transaction taken at the rising edge frees the bus
  int burst_left = 0, gap_left = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_taken = 1'b0;
    end else if (!in_if.valid || in_taken) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        {in_if.pixel_value, in_if.window_width, in_if.window_height,
         in_if.last_pixel} <= pixel_q[0];
        in_if.valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, plus one long hold-off on request
  int stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase++;
    if (long_hold_req && hold_off == 0) begin
      hold_off = 3000;
      long_hold_req = 0;
    end
    if (hold_off > 0) begin
      hold_off--;
      out_if.ready <= 1'b0;
    end else if ((stall_phase / 200) % 3 == 0) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    stats_t e;
    pixel_t p;
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (in_if.valid && in_if.ready) begin
        p = {in_if.pixel_value, in_if.window_width, in_if.window_height,
             in_if.last_pixel};
        void'(pixel_q.pop_front());
        predict_window_stats(p);
        in_taken = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_stats_q.size() == 0) begin
          report_mismatch("unexpected result", out_if.trimmed_mean, 0);
        end else begin
          e = expected_stats_q.pop_front();
          if (out_if.trimmed_mean !== e.mean)
            report_mismatch("trimmed_mean", out_if.trimmed_mean, e.mean);
          if (out_if.trimmed_stddev !== e.sd)
            report_mismatch("trimmed_stddev", out_if.trimmed_stddev, e.sd);
          if (out_if.kept_count !== e.cnt)
            report_mismatch("kept_count", out_if.kept_count, e.cnt);
          if (out_if.status !== e.stat)
            report_mismatch("status", out_if.status, e.stat);
        end
      end
    end
  end

  // watchdog: well above the long receiver hold-off and the slowest window
  always @(posedge clk_i) begin
    if (idle_cycles > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic add_window(int unsigned w, int unsigned ht, int mode, int extra);
    int unsigned total;
    pixel_t p;
    total = side_of(wtms_pkg::SIDE_W'(w)) * side_of(wtms_pkg::SIDE_W'(ht)) + extra;
    if (total < 1) total = 1;
    for (int unsigned i = 0; i < total; i++) begin
      case (mode)
        0: p.pix = wtms_pkg::PIX_W'($urandom);
        1: p.pix = 16'hFFFF;
        2: p.pix = 16'h0000;
        default: p.pix = ($urandom_range(0, 3) == 0) ? wtms_pkg::PIX_W'($urandom) :
                         wtms_pkg::PIX_W'($urandom_range(1000, 1100));
      endcase
      p.w = wtms_pkg::SIDE_W'(w);
      p.h = wtms_pkg::SIDE_W'(ht);
      p.last = (i == total - 1);
      pixel_q.insert(pixel_q.size(), p);
    end
  endtask

  task automatic drain;
    while (pixel_q.size() > 0 || in_if.valid || expected_stats_q.size() > 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_frac(logic idx, logic [wtms_pkg::FRAC_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (v > 17'd65536) v = 17'd65536;
    if (idx == wtms_pkg::REG_LOW) low_frac = v;
    else high_frac = v;
  endtask

  function automatic logic [wtms_pkg::FRAC_W-1:0] rand_frac();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1FFFF;
      default: return wtms_pkg::FRAC_W'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    int unsigned w, ht;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = 1'b0; cfg_data_i = '0;
    in_if.valid = 1'b0; in_if.pixel_value = '0; in_if.window_width = 6'd1;
    in_if.window_height = 6'd1; in_if.last_pixel = 1'b0;
    out_if.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: defaults, extremes, odd sizes, last pixel alone
    add_window(1, 1, 1, 0);          // single sample of full scale
    add_window(3, 3, 1, 0);
    add_window(5, 4, 0, 0);
    add_window(0, 0, 2, 0);          // zero sides act as 1
    add_window(4, 2, 0, 0);          // columns 1..2 kept, all rows kept
    drain();
    write_frac(wtms_pkg::REG_LOW, 17'h1FFFF);  // saturates; empty range
    write_frac(wtms_pkg::REG_HIGH, 17'd0);
    add_window(3, 2, 0, 0);
    drain();
    write_frac(wtms_pkg::REG_LOW, 17'd16384);
    write_frac(wtms_pkg::REG_HIGH, 17'd49152);
    add_window(2, 3, 0, 2);          // too many pixels: extras beyond height dropped
    add_window(63, 2, 3, 0);         // width above max saturates to 32
    add_window(2, 63, 3, 0);         // height above max saturates to 32
    drain();
    write_frac(wtms_pkg::REG_LOW, 17'd0);
    write_frac(wtms_pkg::REG_HIGH, 17'd65536);
    long_hold_req = 1;               // results back up while pixels keep flowing
    for (int i = 0; i < 6; i++) add_window(1, 2, 1, 0);
    drain();

    // random phases with different trim settings
    for (int ph = 0; ph < 8; ph++) begin
      write_frac(wtms_pkg::REG_LOW, rand_frac());
      write_frac(wtms_pkg::REG_HIGH, rand_frac());
      for (int k = 0; k < 6; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          w = $urandom_range(0, 63);
          ht = $urandom_range(0, 63);
          if (w * ht > 40 || w > 32 || ht > 32) begin
            w = $urandom_range(0, 8);
            ht = $urandom_range(0, 5);
          end
        end else begin
          w = $urandom_range(1, 6);
          ht = $urandom_range(1, 6);
        end
        add_window(w, ht, $urandom_range(0, 3), ($urandom_range(0, 7) == 0) ? 1 : 0);
      end
      drain();
    end

    if (errors == 0 && expected_stats_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/wtms_pkg.sv
rtl/wtms_if.sv
rtl/wtms_div.sv
rtl/window_trimmed_mean_stddev_top.sv
tb/sv/testbench.sv
